>>> hw/rtl/ep2cal_pkg.sv
// Shared types and constants for the epoch seconds to calendar converter.
package ep2cal_pkg;

  // Configuration register select (cfg_paddr[2])
  localparam logic REG_LOCAL_ENABLE = 1'b0;
  localparam logic REG_EAST_OFFSET  = 1'b1;

  localparam logic        RST_LOCAL_ENABLE = 1'b1;
  localparam logic [17:0] RST_EAST_OFFSET  = 18'd28800;

  localparam int unsigned PIPE_DEPTH = 7;

  // Seconds split: t = 128 * q1 + r1, q1 = 675 * day + rest
  localparam logic [25:0] DAY_BIAS  = 26'd22118400;  // 675 * 32768
  localparam int unsigned DAY_SH    = 36;
  localparam logic [31:0] DAY_REC   = 32'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam logic [15:0] DAY_UNB   = 16'd32768;
  localparam logic [19:0] Z_SHIFT   = 20'd686700;    // 719468 - 32768
  localparam logic [19:0] ERA5_Z    = 20'd730485;    // 5 * 146097
  localparam logic [19:0] ERA4_Z    = 20'd584388;    // 4 * 146097
  localparam logic [15:0] WDAY_ADJ  = 16'd3;         // 4 - 32768 + 7 * 4681

  // Reciprocals for constant division
  localparam int unsigned HR_SH   = 29;
  localparam logic [31:0] HR_REC  = 32'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam int unsigned MIN_SH  = 18;
  localparam logic [31:0] MIN_REC = 32'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam int unsigned Q4_SH   = 29;
  localparam logic [31:0] Q4_REC  = 32'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam int unsigned YR_SH   = 27;
  localparam logic [31:0] YR_REC  = 32'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam int unsigned WK_SH   = 19;
  localparam logic [31:0] WK_REC  = 32'(((64'd1 << 19) + 64'd6) / 64'd7);

  // Day of year (March based) at which each month starts, March first
  localparam logic [8:0] MSTART [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };
  localparam logic [8:0] JAN_START = 9'd306;
  localparam logic [8:0] MAR_YDAY  = 9'd59;

  typedef struct packed {
    logic [16:0] rem;   // seconds of the day
    logic [17:0] doe;   // day of 400-year era
    logic        era5;  // era 5 when set, else era 4
    logic [15:0] wv;    // day number congruent to weekday mod 7
  } ds_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } tod_t;

  typedef struct packed {
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
  } date_t;

endpackage

>>> hw/rtl/ep2cal_daysplit.sv
// Front stages: zone offset, split into day number and seconds of day.
module ep2cal_daysplit (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        timestamp,
  input  logic               local_enable,
  input  logic [17:0]        east_offset_seconds,
  output ep2cal_pkg::ds_t    ds
);

  logic [32:0] t_r, t_nxt;
  logic [25:0] u_r, u_nxt;
  logic [6:0]  r1_r, r1_nxt;
  logic [15:0] q_r, q_nxt;
  logic [52:0] qprod;
  logic [25:0] qm;
  logic [25:0] rdiff;
  logic [19:0] z;
  logic        era5;
  ep2cal_pkg::ds_t ds_r, ds_nxt;

  always_comb begin
    t_nxt = {timestamp[31], timestamp} +
            (local_enable ? {{15{east_offset_seconds[17]}}, east_offset_seconds} : 33'd0);

    u_nxt  = t_r[32:7] + ep2cal_pkg::DAY_BIAS;
    r1_nxt = t_r[6:0];
    qprod  = 53'(u_nxt) * 53'(ep2cal_pkg::DAY_REC);
    q_nxt  = qprod[ep2cal_pkg::DAY_SH +: 16];

    qm    = 26'(26'(q_r) * 26'd675);
    rdiff = u_r - qm;
    z     = 20'(q_r) + ep2cal_pkg::Z_SHIFT;
    era5  = (z >= ep2cal_pkg::ERA5_Z);
    ds_nxt.rem  = {rdiff[9:0], r1_r};
    ds_nxt.doe  = 18'(z - (era5 ? ep2cal_pkg::ERA5_Z : ep2cal_pkg::ERA4_Z));
    ds_nxt.era5 = era5;
    ds_nxt.wv   = q_r + ep2cal_pkg::WDAY_ADJ;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t_nxt;
      u_r  <= u_nxt;
      r1_r <= r1_nxt;
      q_r  <= q_nxt;
      ds_r <= ds_nxt;
    end
  end

  assign ds = ds_r;

endmodule

>>> hw/rtl/ep2cal_tod.sv
// Time of day stages: hour, minute and second from seconds of the day.
module ep2cal_tod (
  input  logic               clk,
  input  logic               en,
  input  logic [16:0]        rem,
  output ep2cal_pkg::tod_t   tod
);

  logic [16:0] rem4_r, rem4_nxt;
  logic [4:0]  hr4_r, hr4_nxt, hr5_r, hr6_r;
  logic [11:0] ms5_r, ms5_nxt, ms6_r;
  logic [5:0]  min6_r, min6_nxt;
  logic [34:0] hprod;
  logic [24:0] mprod;
  ep2cal_pkg::tod_t tod_r, tod_nxt;

  always_comb begin
    hprod    = 35'(rem) * 35'(ep2cal_pkg::HR_REC);
    hr4_nxt  = hprod[ep2cal_pkg::HR_SH +: 5];
    rem4_nxt = rem;

    ms5_nxt = 12'(rem4_r - 17'(17'(hr4_r) * 17'd3600));

    mprod    = 25'(ms5_r) * 25'(ep2cal_pkg::MIN_REC);
    min6_nxt = mprod[ep2cal_pkg::MIN_SH +: 6];

    tod_nxt.hour   = hr6_r;
    tod_nxt.minute = min6_r;
    tod_nxt.second = 6'(ms6_r - 12'(12'(min6_r) * 12'd60));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem4_r <= rem4_nxt;
      hr4_r  <= hr4_nxt;
      hr5_r  <= hr4_r;
      ms5_r  <= ms5_nxt;
      hr6_r  <= hr5_r;
      ms6_r  <= ms5_r;
      min6_r <= min6_nxt;
      tod_r  <= tod_nxt;
    end
  end

  assign tod = tod_r;

endmodule

>>> hw/rtl/ep2cal_civil.sv
// Date stages: year, month, day, weekday and day of year from the day number.
module ep2cal_civil (
  input  logic               clk,
  input  logic               en,
  input  logic [17:0]        doe,
  input  logic               era5,
  input  logic [15:0]        wv,
  output ep2cal_pkg::date_t  date
);

  // stage 4
  logic [17:0] doe4_r;
  logic        era4_r;
  logic [6:0]  a4_r, a4_nxt;
  logic [1:0]  b4_r, b4_nxt;
  logic [15:0] wv4_r;
  logic [13:0] wq4_r, wq4_nxt;
  logic [36:0] aprod;
  logic [32:0] wprod;
  // stage 5
  logic [17:0] doe5_r, num;
  logic        era5_r;
  logic [8:0]  yoe5_r, yoe5_nxt;
  logic [2:0]  wd5_r, wd5_nxt;
  logic [36:0] yprod;
  // stage 6
  logic [8:0]  doy6_r, doy6_nxt, yoe6_r;
  logic        era6_r, leap6_r, leap6_nxt;
  logic [2:0]  wd6_r;
  logic [1:0]  yc;
  // stage 7
  logic [3:0]  mp;
  logic        jf;
  logic [9:0]  yrs;
  ep2cal_pkg::date_t date_r, date_nxt;

  always_comb begin
    aprod   = 37'(doe) * 37'(ep2cal_pkg::Q4_REC);
    a4_nxt  = aprod[ep2cal_pkg::Q4_SH +: 7];
    b4_nxt  = 2'(doe >= 18'd36524) + 2'(doe >= 18'd73048) + 2'(doe >= 18'd109572);
    wprod   = 33'(wv) * 33'(ep2cal_pkg::WK_REC);
    wq4_nxt = wprod[ep2cal_pkg::WK_SH +: 14];

    num      = doe4_r - 18'(a4_r) + 18'(b4_r);
    yprod    = 37'(num) * 37'(ep2cal_pkg::YR_REC);
    yoe5_nxt = yprod[ep2cal_pkg::YR_SH +: 9];
    wd5_nxt  = 3'(wv4_r - 16'(16'(wq4_r) * 16'd7));

    yc        = 2'(yoe5_r >= 9'd100) + 2'(yoe5_r >= 9'd200) + 2'(yoe5_r >= 9'd300);
    doy6_nxt  = 9'(doe5_r - (18'(18'(yoe5_r) * 18'd365) + 18'(yoe5_r[8:2]) - 18'(yc)));
    leap6_nxt = (yoe5_r[1:0] == 2'd0) && (yoe5_r != 9'd100) && (yoe5_r != 9'd200) &&
                (yoe5_r != 9'd300);

    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy6_r >= ep2cal_pkg::MSTART[i]) mp = 4'(i);
    end
    jf  = (doy6_r >= ep2cal_pkg::JAN_START);
    yrs = 10'(yoe6_r) + (era6_r ? 10'd400 : 10'd0) - 10'd300 + 10'(jf);
    date_nxt.day_of_month     = 5'(doy6_r - ep2cal_pkg::MSTART[mp] + 9'd1);
    date_nxt.month_index      = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
    date_nxt.years_since_1900 = yrs[7:0];
    date_nxt.weekday          = wd6_r;
    date_nxt.day_of_year      = jf ? doy6_r - ep2cal_pkg::JAN_START
                                   : doy6_r + ep2cal_pkg::MAR_YDAY + 9'(leap6_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doe4_r  <= doe;
      era4_r  <= era5;
      a4_r    <= a4_nxt;
      b4_r    <= b4_nxt;
      wv4_r   <= wv;
      wq4_r   <= wq4_nxt;
      doe5_r  <= doe4_r;
      era5_r  <= era4_r;
      yoe5_r  <= yoe5_nxt;
      wd5_r   <= wd5_nxt;
      doy6_r  <= doy6_nxt;
      yoe6_r  <= yoe5_r;
      era6_r  <= era5_r;
      leap6_r <= leap6_nxt;
      wd6_r   <= wd5_r;
      date_r  <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

>>> hw/rtl/epoch_seconds_to_calendar.sv
// Top level: converts signed epoch seconds into broken-down calendar time.
//
// Input stream: one word per timestamp (signed seconds since 1970-01-01 UTC).
// Output stream: one word per input with second, minute, hour, day of month,
// month (January = 0), years since 1900, weekday (Sunday = 0), day of year.
// Config port: register 0 at 0x0 is local_enable, register 1 at 0x4 is the
// signed east offset in seconds, added to the timestamp when local_enable=1.
//
// Seven register stages: an accepted word shows up as out_tvalid once it has
// passed all seven; while the output is not stalled, the pipeline takes one
// word per cycle. No path through a stage has more than one constant multiply,
// the widest being the 26x27 reciprocal multiply that splits seconds into days.
// The whole pipeline advances together: when the output word is not taken,
// every stage holds and in_tready drops, so nothing is lost or repeated; empty
// stages keep filling while the output slot is empty.
// Reset clears all valid bits, sets local_enable to 1 and the offset to
// 28800 (UTC+8).
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] timestamp
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // [5:0] second, [11:6] minute, [16:12] hour,
                                    // [21:17] day_of_month, [25:22] month_index,
                                    // [33:26] years_since_1900, [36:34] weekday,
                                    // [45:37] day_of_year, [47:46] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned NS = ep2cal_pkg::PIPE_DEPTH;

  logic            local_enable_r, local_enable_nxt;
  logic [17:0]     east_offset_r, east_offset_nxt;
  logic [NS-1:0]   v_r, v_nxt;
  logic            en;
  logic            cfg_wr;
  ep2cal_pkg::ds_t   ds;
  ep2cal_pkg::tod_t  tod;
  ep2cal_pkg::date_t date;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    local_enable_nxt = local_enable_r;
    east_offset_nxt  = east_offset_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        ep2cal_pkg::REG_LOCAL_ENABLE: local_enable_nxt = cfg_pwdata[0];
        ep2cal_pkg::REG_EAST_OFFSET:  east_offset_nxt  = cfg_pwdata[17:0];
        default: ;
      endcase
    end
    case (cfg_paddr[2])
      ep2cal_pkg::REG_LOCAL_ENABLE: cfg_prdata = {31'd0, local_enable_r};
      ep2cal_pkg::REG_EAST_OFFSET:  cfg_prdata = {{14{east_offset_r[17]}}, east_offset_r};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_enable_r <= ep2cal_pkg::RST_LOCAL_ENABLE;
      east_offset_r  <= ep2cal_pkg::RST_EAST_OFFSET;
    end else begin
      local_enable_r <= local_enable_nxt;
      east_offset_r  <= east_offset_nxt;
    end
  end

  // pipeline control
  assign en        = !v_r[NS-1] || out_tready;
  assign in_tready = en;
  assign v_nxt     = en ? {v_r[NS-2:0], in_tvalid} : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  ep2cal_daysplit u_daysplit (
    .clk                 (clk),
    .en                  (en),
    .timestamp           (in_tdata),
    .local_enable        (local_enable_r),
    .east_offset_seconds (east_offset_r),
    .ds                  (ds)
  );

  ep2cal_tod u_tod (
    .clk (clk),
    .en  (en),
    .rem (ds.rem),
    .tod (tod)
  );

  ep2cal_civil u_civil (
    .clk  (clk),
    .en   (en),
    .doe  (ds.doe),
    .era5 (ds.era5),
    .wv   (ds.wv),
    .date (date)
  );

  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = {2'b00, date.day_of_year, date.weekday, date.years_since_1900,
                       date.month_index, date.day_of_month, tod.hour, tod.minute,
                       tod.second};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted word not captured in first stage");

  a_day_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> ds.rem < 17'd86400 && ds.doe <= 18'd146096)
    else $error("day split out of range");

  a_out_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> tod.second < 6'd60 && tod.minute < 6'd60 && tod.hour < 5'd24 &&
                   date.month_index < 4'd12 && date.weekday < 3'd7 &&
                   date.day_of_month != 5'd0 && date.day_of_year < 9'd366)
    else $error("calendar field out of range");

endmodule
